>>> rtl/core/ffl_pkg.sv
// ----------------------------------------------------------------------------
// ffl_pkg: shared types and constants of the first-fit free-list allocator
// Command codes, status codes, the queued item and the sequencer states.
// ----------------------------------------------------------------------------
package ffl_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;

  // Status codes on the result channel.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_LOST   = 2'd2;

  // Page rounding constants.
  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  // Classified operation.
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY
  } op_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] size;
  } item_t;

  // Queue head offered from the front part to the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_FRD,
    S_FCHK,
    S_FDEC,
    S_DRD,
    S_DWR,
    S_URD,
    S_UWR,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/ffl_ram.sv
// ----------------------------------------------------------------------------
// ffl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ffl_front.sv
// ----------------------------------------------------------------------------
// ffl_front: command intake and classification
// Rounds the size, classifies the command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module ffl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_region_addr,
  input  logic [31:0]        in_region_size,
  input  logic               in_round_to_page,
  output ffl_pkg::head_t     head,
  input  logic               pop
);

  ffl_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  ffl_pkg::item_t item;
  logic           push;

  // Classification and optional page rounding.
  always_comb begin
    item.addr = in_region_addr;
    item.size = in_round_to_page ?
                ((in_region_size + ffl_pkg::PAGE_ADD) & ffl_pkg::PAGE_MASK) :
                in_region_size;
    unique case (in_cmd)
      ffl_pkg::CMD_ALLOC: item.op = ffl_pkg::OP_ALLOC;
      ffl_pkg::CMD_FREE:  item.op = ffl_pkg::OP_FREE;
      default:            item.op = ffl_pkg::OP_QUERY;
    endcase
  end

  assign busy = (fill_r == 2'd2);
  assign push = start && !busy;
  assign head.valid = (fill_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> rtl/core/ffl_back.sv
// ----------------------------------------------------------------------------
// ffl_back: region table sequencer
// Searches, updates and shifts the sorted region table and emits one result.
// ----------------------------------------------------------------------------
module ffl_back #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ffl_pkg::head_t                     head,
  output logic                               pop,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_alloc_addr,
  output logic [31:0]                        out_free_total,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] out_entries_used,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] out_entries_peak,
  output logic [31:0]                        out_lost_frees,
  output logic [31:0]                        out_lost_bytes
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] ONE  = CW'(1);

  ffl_pkg::state_t state_r, state_nxt;
  ffl_pkg::op_t    op_r, op_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [31:0]     size_r, size_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   peak_r, peak_nxt;
  logic [31:0]     total_r, total_nxt;
  logic [31:0]     lost_cnt_r, lost_cnt_nxt;
  logic [31:0]     lost_tot_r, lost_tot_nxt;
  logic [63:0]     prev_r, prev_nxt;
  logic [63:0]     cur_r, cur_nxt;
  logic [31:0]     got_r, got_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [63:0]     wdata;
  logic [AW-1:0]   raddr;
  logic [63:0]     rdata;
  logic [31:0]     rd_s, rd_l, prev_s, prev_l, cur_s, cur_l;
  logic            left, right;

  ffl_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s   = rdata[63:32];
  assign rd_l   = rdata[31:0];
  assign prev_s = prev_r[63:32];
  assign prev_l = prev_r[31:0];
  assign cur_s  = cur_r[63:32];
  assign cur_l  = cur_r[31:0];
  assign left   = (k_r != '0) && ((prev_s + prev_l) == addr_r);
  assign right  = (k_r != count_r) && ((addr_r + size_r) == cur_s);

  // Sequencer: next state, table accesses and bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    total_nxt     = total_r;
    lost_cnt_nxt  = lost_cnt_r;
    lost_tot_nxt  = lost_tot_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    got_nxt       = got_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = k_r[AW-1:0];
    wdata         = rdata;
    raddr         = k_r[AW-1:0];
    unique case (state_r)
      ffl_pkg::S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          op_nxt     = head.item.op;
          addr_nxt   = head.item.addr;
          size_nxt   = head.item.size;
          k_nxt      = '0;
          got_nxt    = '0;
          status_nxt = ffl_pkg::STATUS_OK;
          unique case (head.item.op)
            ffl_pkg::OP_ALLOC: state_nxt = ffl_pkg::S_ARD;
            ffl_pkg::OP_FREE:  state_nxt = ffl_pkg::S_FRD;
            default:           state_nxt = ffl_pkg::S_DONE;
          endcase
        end
      end
      // First-fit scan for an allocation.
      ffl_pkg::S_ARD: begin
        if (k_r == count_r) begin
          status_nxt = ffl_pkg::STATUS_NO_FIT;
          state_nxt  = ffl_pkg::S_DONE;
        end else begin
          state_nxt = ffl_pkg::S_ACHK;
        end
      end
      ffl_pkg::S_ACHK: begin
        if (rd_l >= size_r) begin
          got_nxt   = rd_s;
          total_nxt = total_r - size_r;
          if (rd_l == size_r) begin
            j_nxt     = k_r;
            state_nxt = ffl_pkg::S_DRD;
          end else begin
            we        = 1'b1;
            wdata     = {rd_s + size_r, rd_l - size_r};
            state_nxt = ffl_pkg::S_DONE;
          end
        end else begin
          k_nxt     = k_r + ONE;
          state_nxt = ffl_pkg::S_ARD;
        end
      end
      // Scan for the first region that starts above the freed address.
      ffl_pkg::S_FRD: begin
        state_nxt = (k_r == count_r) ? ffl_pkg::S_FDEC : ffl_pkg::S_FCHK;
      end
      ffl_pkg::S_FCHK: begin
        if (rd_s > addr_r) begin
          cur_nxt   = rdata;
          state_nxt = ffl_pkg::S_FDEC;
        end else begin
          prev_nxt  = rdata;
          k_nxt     = k_r + ONE;
          state_nxt = ffl_pkg::S_FRD;
        end
      end
      // Merge with a neighbour, insert, or count the free as lost.
      ffl_pkg::S_FDEC: begin
        if (left) begin
          we        = 1'b1;
          waddr     = AW'(k_r - ONE);
          wdata     = {prev_s, prev_l + size_r + (right ? cur_l : 32'd0)};
          total_nxt = total_r + size_r;
          j_nxt     = k_r;
          state_nxt = right ? ffl_pkg::S_DRD : ffl_pkg::S_DONE;
        end else if (right) begin
          we        = 1'b1;
          wdata     = {addr_r, cur_l + size_r};
          total_nxt = total_r + size_r;
          state_nxt = ffl_pkg::S_DONE;
        end else if (count_r != FULL) begin
          total_nxt = total_r + size_r;
          j_nxt     = count_r;
          state_nxt = ffl_pkg::S_URD;
        end else begin
          status_nxt   = ffl_pkg::STATUS_LOST;
          lost_cnt_nxt = lost_cnt_r + 32'd1;
          lost_tot_nxt = lost_tot_r + size_r;
          state_nxt    = ffl_pkg::S_DONE;
        end
      end
      // Close the gap at entry j by moving the entries above it down.
      ffl_pkg::S_DRD: begin
        raddr = AW'(j_r + ONE);
        if ((j_r + ONE) >= count_r) begin
          count_nxt = count_r - ONE;
          state_nxt = ffl_pkg::S_DONE;
        end else begin
          state_nxt = ffl_pkg::S_DWR;
        end
      end
      ffl_pkg::S_DWR: begin
        we        = 1'b1;
        waddr     = j_r[AW-1:0];
        j_nxt     = j_r + ONE;
        state_nxt = ffl_pkg::S_DRD;
      end
      // Open a gap at entry k by moving the entries above it up.
      ffl_pkg::S_URD: begin
        raddr = AW'(j_r - ONE);
        if (j_r == k_r) begin
          we        = 1'b1;
          wdata     = {addr_r, size_r};
          count_nxt = count_r + ONE;
          if (peak_r < count_r + ONE) begin
            peak_nxt = count_r + ONE;
          end
          state_nxt = ffl_pkg::S_DONE;
        end else begin
          state_nxt = ffl_pkg::S_UWR;
        end
      end
      ffl_pkg::S_UWR: begin
        we        = 1'b1;
        waddr     = j_r[AW-1:0];
        j_nxt     = j_r - ONE;
        state_nxt = ffl_pkg::S_URD;
      end
      ffl_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ffl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffl_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ffl_pkg::S_IDLE;
      count_r    <= '0;
      peak_r     <= '0;
      total_r    <= '0;
      lost_cnt_r <= '0;
      lost_tot_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      peak_r     <= peak_nxt;
      total_r    <= total_nxt;
      lost_cnt_r <= lost_cnt_nxt;
      lost_tot_r <= lost_tot_nxt;
      out_valid  <= out_valid_nxt;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    size_r   <= size_nxt;
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    prev_r   <= prev_nxt;
    cur_r    <= cur_nxt;
    got_r    <= got_nxt;
    status_r <= status_nxt;
    if (out_valid_nxt) begin
      out_status       <= status_r;
      out_alloc_addr   <= got_r;
      out_free_total   <= total_r;
      out_entries_used <= count_r;
      out_entries_peak <= peak_r;
      out_lost_frees   <= lost_cnt_r;
      out_lost_bytes   <= lost_tot_r;
    end
  end

  // The table never holds more regions than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("region count exceeds table size");

  // The peak never falls below the current region count.
  a_peak_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r) else $error("peak below region count");

  // A result strobe lasts one cycle and follows the done state.
  a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ffl_pkg::S_DONE)
    else $error("result strobe without completed command");

  // A command is only taken from the queue while the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ffl_pkg::S_IDLE && head.valid)
    else $error("queue popped outside idle");

endmodule

>>> rtl/core/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit free-list allocator with merging
// Keeps a sorted table of free regions and serves allocate, free and query.
//
//   Channel   Ports                         Transfer
//   input     start, busy, in_*             start high while busy low
//   result    out_valid, out_*              one cycle with out_valid high
//
// An allocate or free reads the table one entry at a time: one read per entry
// scanned, and one read and one write per entry moved. The scan stops where
// the shift begins, so a command passes over a full table at most once; the
// single read port of the region table sets that pace. Up to two commands
// wait in the input queue while the sequencer works, and busy rises when it is full.
// Reset is synchronous and clears counters; the table needs no clearing.
// The receiver cannot stall: every result is shown for one cycle.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic [31:0]                        in_region_addr,
  input  logic [31:0]                        in_region_size,
  input  logic                               in_round_to_page,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_alloc_addr,
  output logic [31:0]                        out_free_total,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] out_entries_used,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] out_entries_peak,
  output logic [31:0]                        out_lost_frees,
  output logic [31:0]                        out_lost_bytes
);

  ffl_pkg::head_t head;
  logic           pop;

  // Intake and queue.
  ffl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_region_addr   (in_region_addr),
    .in_region_size   (in_region_size),
    .in_round_to_page (in_round_to_page),
    .head             (head),
    .pop              (pop)
  );

  // Table sequencer.
  ffl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_addr   (out_alloc_addr),
    .out_free_total   (out_free_total),
    .out_entries_used (out_entries_used),
    .out_entries_peak (out_entries_peak),
    .out_lost_frees   (out_lost_frees),
    .out_lost_bytes   (out_lost_bytes)
  );

endmodule

>>> verif/ffl_checker.sv
// ----------------------------------------------------------------------------
// ffl_checker: result checker for the first-fit free-list allocator
// Watches both channels, keeps its own copy of the free-region table,
// predicts the result of every accepted command and compares it field by
// field with the result that the block reports.
// ----------------------------------------------------------------------------
module ffl_checker #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CW = $clog2(TABLE_ENTRIES+1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic [1:0]    in_cmd,
  input  logic [31:0]   in_region_addr,
  input  logic [31:0]   in_region_size,
  input  logic          in_round_to_page,
  input  logic          out_valid,
  input  logic [1:0]    out_status,
  input  logic [31:0]   out_alloc_addr,
  input  logic [31:0]   out_free_total,
  input  logic [CW-1:0] out_entries_used,
  input  logic [CW-1:0] out_entries_peak,
  input  logic [31:0]   out_lost_frees,
  input  logic [31:0]   out_lost_bytes,
  output int            fail_count,
  output int            pending,
  output int            checked
);
  import ffl_pkg::*;

  typedef struct {
    logic [1:0]    status;
    logic [31:0]   addr;
    logic [31:0]   total;
    logic [CW-1:0] used;
    logic [CW-1:0] peak;
    logic [31:0]   lost_n;
    logic [31:0]   lost_b;
  } alloc_result_t;

  // Mirror of the block's free-region table and counters.
  logic [31:0]   free_base [TABLE_ENTRIES];
  logic [31:0]   free_len  [TABLE_ENTRIES];
  int            n_regions;
  int            n_peak;
  logic [31:0]   dropped_cnt;
  logic [31:0]   dropped_bytes;
  alloc_result_t expected_q[$];

  assign pending = expected_q.size();

  // Removes entry k and closes the gap.
  function automatic void remove_region(int k);
    for (int j = k; j < n_regions - 1; j++) begin
      free_base[j] = free_base[j+1];
      free_len[j]  = free_len[j+1];
    end
    n_regions--;
  endfunction

  // First fit: the lowest region that is long enough gives up its start.
  function automatic logic [1:0] take_first_fit(logic [31:0] size, output logic [31:0] got);
    got = '0;
    for (int k = 0; k < n_regions; k++) begin
      if (free_len[k] >= size) begin
        got = free_base[k];
        free_base[k] += size;
        free_len[k]  -= size;
        if (free_len[k] == 0) remove_region(k);
        return STATUS_OK;
      end
    end
    return STATUS_NO_FIT;
  endfunction

  // Return of a region: merge with neighbours that touch, else insert.
  function automatic logic [1:0] return_region(logic [31:0] addr, logic [31:0] size);
    int k;
    k = 0;
    while (k < n_regions && free_base[k] <= addr) k++;
    if (k > 0 && free_base[k-1] + free_len[k-1] == addr) begin
      free_len[k-1] += size;
      if (k < n_regions && addr + size == free_base[k]) begin
        free_len[k-1] += free_len[k];
        remove_region(k);
      end
      return STATUS_OK;
    end
    if (k < n_regions && addr + size == free_base[k]) begin
      free_base[k] = addr;
      free_len[k] += size;
      return STATUS_OK;
    end
    if (n_regions < TABLE_ENTRIES) begin
      for (int j = n_regions; j > k; j--) begin
        free_base[j] = free_base[j-1];
        free_len[j]  = free_len[j-1];
      end
      n_regions++;
      if (n_peak < n_regions) n_peak = n_regions;
      free_base[k] = addr;
      free_len[k]  = size;
      return STATUS_OK;
    end
    dropped_cnt++;
    dropped_bytes += size;
    return STATUS_LOST;
  endfunction

  function automatic alloc_result_t predict_command(logic [1:0] cmd, logic [31:0] addr,
                                                    logic [31:0] size, logic rnd);
    alloc_result_t r;
    r.status = STATUS_OK;
    r.addr   = '0;
    r.total  = '0;
    if (rnd) size = (size + PAGE_ADD) & PAGE_MASK;
    if (cmd == CMD_ALLOC) r.status = take_first_fit(size, r.addr);
    else if (cmd == CMD_FREE) r.status = return_region(addr, size);
    for (int k = 0; k < n_regions; k++) r.total += free_len[k];
    r.used   = CW'(n_regions);
    r.peak   = CW'(n_peak);
    r.lost_n = dropped_cnt;
    r.lost_b = dropped_bytes;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Results are compared before the new transfer is predicted; a result can
  // never belong to a command accepted at the same edge.
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst_n) begin
      n_regions     = 0;
      n_peak        = 0;
      dropped_cnt   = '0;
      dropped_bytes = '0;
      fail_count    = 0;
      checked       = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("status", 32'(e.status), 32'(out_status));
          compare_field("alloc_addr", e.addr, out_alloc_addr);
          compare_field("free_total", e.total, out_free_total);
          compare_field("entries_used", 32'(e.used), 32'(out_entries_used));
          compare_field("entries_peak", 32'(e.peak), 32'(out_entries_peak));
          compare_field("lost_frees", e.lost_n, out_lost_frees);
          compare_field("lost_bytes", e.lost_b, out_lost_bytes);
          checked++;
        end
      end
      if (start && !busy)
        expected_q.push_back(predict_command(in_cmd, in_region_addr, in_region_size,
                                             in_round_to_page));
    end
  end

endmodule

>>> verif/tb_first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator: testbench of the free-list allocator
// Drives directed corner cases, then random allocate, free and query
// commands with random gaps, fills the table to force lost frees, and
// leaves all checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator;
  import ffl_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int CW = $clog2(TABLE_ENTRIES+1);
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    in_cmd = CMD_QUERY;
  logic [31:0]   in_region_addr = '0;
  logic [31:0]   in_region_size = '0;
  logic          in_round_to_page = 1'b0;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [31:0]   out_alloc_addr;
  logic [31:0]   out_free_total;
  logic [CW-1:0] out_entries_used;
  logic [CW-1:0] out_entries_peak;
  logic [31:0]   out_lost_frees;
  logic [31:0]   out_lost_bytes;
  int            fail_count;
  int            pending;
  int            checked;
  int            n_sent;
  int            n_alloc;
  int            n_free;
  int            idle_cycles;

  always #2 clk = ~clk;

  first_fit_free_list_allocator #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

  ffl_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (.*);

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one command and holds it until the transfer completes.
  task automatic send(logic [1:0] cmd, logic [31:0] addr, logic [31:0] size, logic rnd);
    start            <= 1'b1;
    in_cmd           <= cmd;
    in_region_addr   <= addr;
    in_region_size   <= size;
    in_round_to_page <= rnd;
    do @(posedge clk); while (busy);
    n_sent++;
    if (cmd == CMD_ALLOC) n_alloc++;
    else if (cmd == CMD_FREE) n_free++;
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  task automatic random_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random command: mostly page-grid traffic so that merges and first-fit
  // splits happen, with some fully random values and queries mixed in.
  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send(CMD_ALLOC, $urandom(), $urandom_range(0, 4) * 32'h1000 + $urandom_range(0, 1) *
           $urandom_range(0, 32'hfff), 1'($urandom()));
    else if (r < 75)
      send(CMD_FREE, $urandom_range(0, 63) * 32'h1000, $urandom_range(1, 3) * 32'h1000,
           1'($urandom()));
    else if (r < 88)
      send(2'($urandom_range(0, 1)), $urandom(), $urandom(), 1'($urandom()));
    else
      send(2'($urandom_range(CMD_QUERY, CMD_SPARE)), $urandom(), $urandom(), 1'($urandom()));
    random_gap();
  endtask

  initial begin
    n_sent = 0;
    n_alloc = 0;
    n_free = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, merges on each side, zero sizes, rounding.
    send(CMD_QUERY, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send(CMD_SPARE, 32'h0, 32'h0, 1'b0);
    send(CMD_ALLOC, 32'h0, 32'h10, 1'b0);
    send(CMD_FREE, 32'h0, 32'h1000, 1'b0);
    send(CMD_ALLOC, 32'hffff_ffff, 32'h0, 1'b1);
    send(CMD_ALLOC, 32'h0, 32'h10, 1'b0);
    send(CMD_FREE, 32'h3000, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h1000, 32'h2000, 1'b0);
    send(CMD_FREE, 32'h5000, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h4000, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h8000, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h7000, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h0, 32'h0, 1'b0);
    send(CMD_ALLOC, 32'h0, 32'h0, 1'b0);
    send(CMD_ALLOC, 32'h0, 32'h0, 1'b0);
    send(CMD_FREE, 32'h20000, 32'h0, 1'b0);
    send(CMD_ALLOC, 32'h0, 32'hffff_ffff, 1'b1);
    send(CMD_ALLOC, 32'h0, 32'h1, 1'b1);
    send(CMD_ALLOC, 32'h0, 32'hffff_ffff, 1'b0);
    send(CMD_FREE, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send(CMD_ALLOC, 32'h0, 32'h1000, 1'b0);
    send(CMD_FREE, 32'h8000_0000, 32'h7fff_ffff, 1'b1);

    // Random mixed traffic.
    repeat (320) random_command();

    // Let the block drain completely before the next phase.
    start <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    // Fill the table with regions that never touch, then keep freeing so
    // that lost frees are counted.
    for (int k = 0; k < TABLE_ENTRIES + 20; k++) begin
      send(CMD_FREE, 32'h9000_0000 + k * 32'h10_0000 + $urandom_range(0, 32'hff),
           $urandom_range(1, 32'hffff), 1'b0);
      random_gap();
    end
    repeat (150) random_command();

    // Drain the table with allocations, then finish with mixed traffic.
    repeat (150) begin
      send(CMD_ALLOC, $urandom(), $urandom_range(0, 32'h1_0000), 1'($urandom()));
      random_gap();
    end
    repeat (40) random_command();

    start <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk);

    $display("Sent %0d commands: %0d allocate, %0d free, the rest queries.",
             n_sent, n_alloc, n_free);
    $display("Checked %0d results, including table-full frees and merges.", checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ffl_pkg.sv
rtl/core/ffl_ram.sv
rtl/core/ffl_front.sv
rtl/core/ffl_back.sv
rtl/core/first_fit_free_list_allocator.sv
verif/ffl_checker.sv
verif/tb_first_fit_free_list_allocator.sv
